/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Expects i_clk and a synchronous active-low i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/rws_pkg.sv */
// Package for the roulette wheel selector: field widths, op codes, defaults.
// No dependencies.
`default_nettype none

package rws_pkg;

    // request and response field widths
    localparam int OP_W    = 2;
    localparam int SCORE_W = 16;
    localparam int RAND_W  = 14;
    localparam int IDX_W   = 8;
    localparam int TOTAL_W = 24;
    localparam int COUNT_W = 9;

    // op codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd2;

    // parameter defaults
    localparam int DEPTH_DEF      = 256;
    localparam int SCORE_BITS_DEF = 16;

    // wheel scale of the random draw and saturation value of the sum
    localparam logic [RAND_W-1:0]  WHEEL_SCALE = 14'd10000;
    localparam logic [TOTAL_W-1:0] SUM_MAX     = 24'hFF_FFFF;

    // width of total*rand, also holds entry*scale + scale-1
    localparam int PROD_W = TOTAL_W + RAND_W;

endpackage

`default_nettype wire

/* hw/rtl/rws_if.sv */
// Valid/ready channel interfaces for the roulette wheel selector.
// Depends on rws_pkg for field widths.
`default_nettype none

interface rws_req_if;
    logic                        valid;
    logic                        ready;
    logic [rws_pkg::OP_W-1:0]    op;
    logic [rws_pkg::SCORE_W-1:0] score;
    logic [rws_pkg::RAND_W-1:0]  rand_value;

    modport source (output valid, op, score, rand_value, input ready);
    modport sink   (input valid, op, score, rand_value, output ready);
endinterface

interface rws_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rws_pkg::IDX_W-1:0]   selected_index;
    logic [rws_pkg::TOTAL_W-1:0] total_weight;
    logic [rws_pkg::COUNT_W-1:0] entry_total;
    logic                        overflow;

    modport source (output valid, selected_index, total_weight, entry_total, overflow,
                    input ready);
    modport sink   (input valid, selected_index, total_weight, entry_total, overflow,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/roulette_wheel_selector.sv */
// Roulette wheel selector, top level. Uses rws_pkg, rws_if, assert_macros.svh.
// One request at a time. Clear and load: accept, then S_DONE, then the response register;
//   the next request is taken once S_DONE hands off. Select: S_MUL multiply, S_SETUP, a
//   binary search in S_SRCH with one read of the single memory read port per step, S_DONE.
// A new request is taken while the previous response waits; a second finished one holds.
// Synchronous active-low reset empties the wheel; the memory itself is not cleared.
`default_nettype none
`include "assert_macros.svh"

module roulette_wheel_selector #(
    parameter int DEPTH      = rws_pkg::DEPTH_DEF,
    parameter int SCORE_BITS = rws_pkg::SCORE_BITS_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    rws_req_if.sink   i_req,
    rws_rsp_if.source o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // memory address bits
    localparam int CW = $clog2(DEPTH + 1);                   // count, holds DEPTH
    localparam int SB = (SCORE_BITS < rws_pkg::SCORE_W) ? SCORE_BITS : rws_pkg::SCORE_W;
    localparam logic [rws_pkg::SCORE_W-1:0] SCORE_MASK =
        rws_pkg::SCORE_W'((33'd1 << SB) - 33'd1);
    localparam int TW = rws_pkg::TOTAL_W;
    localparam int PW = rws_pkg::PROD_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_SETUP = 5'b00100,
        S_SRCH  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // control
    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count;
    logic [TW-1:0]               r_total;
    logic                        r_out_valid;

    // datapath
    logic [rws_pkg::RAND_W-1:0]   r_rand;
    logic                         r_drop;
    logic [PW-1:0]                r_prod;
    logic [PW-1:0]                cum_scaled;
    logic                         cum_hit;
    logic [CW-1:0]                r_lo, r_hi, n_lo, n_hi;
    logic [AW-1:0]                r_mid;
    logic [CW:0]                  mid_sum;
    logic [AW-1:0]                rd_addr;

    // cumulative-sum memory, one read and one write port
    logic [TW-1:0] mem [DEPTH];
    logic [TW-1:0] r_rd_data;
    logic          mem_we;
    logic [TW-1:0] wr_data;

    // output register
    logic [rws_pkg::IDX_W-1:0]   r_o_idx;
    logic [TW-1:0]               r_o_total;
    logic [rws_pkg::COUNT_W-1:0] r_o_count;
    logic                        r_o_ovf;

    logic                        req_fire;
    logic [rws_pkg::SCORE_W-1:0] score_eff;
    logic [TW:0]                 sum_ext;
    logic                        table_full;
    logic [CW-1:0]               sel_idx;
    logic                        out_load;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    assign score_eff  = i_req.score & SCORE_MASK;
    assign sum_ext    = {1'b0, r_total} + (TW + 1)'(score_eff);
    assign wr_data    = sum_ext[TW] ? rws_pkg::SUM_MAX : sum_ext[TW-1:0];
    assign table_full = (r_count == CW'(DEPTH));
    assign mem_we     = req_fire && (i_req.op == rws_pkg::OP_LOAD) && !table_full;

    // entry reaches floor(prod/scale) exactly when entry*scale + scale-1 >= prod,
    // so no division is needed
    assign cum_scaled = PW'(r_rd_data) * PW'(rws_pkg::WHEEL_SCALE)
                      + PW'(rws_pkg::WHEEL_SCALE) - PW'(1);
    assign cum_hit    = (cum_scaled >= r_prod);

    // binary search for the first entry at or above the threshold; answer in [lo, hi]
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        case (r_state)
            S_SETUP: begin
                n_lo = '0;
                n_hi = r_count;
            end
            S_SRCH: begin
                if (cum_hit) begin
                    n_hi = CW'(r_mid);
                end else begin
                    n_lo = CW'(r_mid) + CW'(1);
                end
            end
            default: begin
                n_lo = r_lo;
                n_hi = r_hi;
            end
        endcase
    end

    assign mid_sum = {1'b0, n_lo} + {1'b0, n_hi};
    assign rd_addr = mid_sum[AW:1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = (i_req.op == rws_pkg::OP_SELECT) ? S_MUL : S_DONE;
                end
            end
            S_MUL:   n_state = S_SETUP;
            S_SETUP: n_state = (n_lo < n_hi) ? S_SRCH : S_DONE;
            S_SRCH:  n_state = (n_lo < n_hi) ? S_SRCH : S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign sel_idx  = (r_lo == r_count) ? '0 : r_lo;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (req_fire) begin
                case (i_req.op)
                    rws_pkg::OP_CLEAR: begin
                        r_count <= '0;
                        r_total <= '0;
                    end
                    rws_pkg::OP_LOAD: begin
                        if (!table_full) begin
                            r_count <= r_count + CW'(1);
                            r_total <= wr_data;
                        end
                    end
                    default: begin
                        r_count <= r_count;
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rand <= i_req.rand_value;
            r_drop <= (i_req.op == rws_pkg::OP_LOAD) && table_full;
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_total) * PW'(r_rand);
        end
        if (req_fire) begin
            r_lo <= '0;
            r_hi <= '0;
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        r_mid <= rd_addr;
        if (out_load) begin
            r_o_idx   <= rws_pkg::IDX_W'(sel_idx);
            r_o_total <= r_total;
            r_o_count <= rws_pkg::COUNT_W'(r_count);
            r_o_ovf   <= r_drop;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.selected_index = r_o_idx;
    assign o_rsp.total_weight   = r_o_total;
    assign o_rsp.entry_total    = r_o_count;
    assign o_rsp.overflow       = r_o_ovf;

    // a load into a table with room grows the count by one
    `ASSERT_NEXT(a_load_count, req_fire && (i_req.op == rws_pkg::OP_LOAD) && !table_full,
                 r_count == $past(r_count) + CW'(1))
    // the search window is never empty while searching
    `ASSERT_IMPL(a_srch_window, r_state == S_SRCH, r_lo < r_hi)
    // a dropped load is only reported with a full table
    `ASSERT_IMPL(a_drop_full, (r_state == S_DONE) && r_drop, table_full)
    // at done the search result is at most the entry count, which is at most DEPTH
    `ASSERT_IMPL(a_sel_range, r_state == S_DONE, (r_lo <= r_count) && (r_count <= CW'(DEPTH)))

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking bench for the roulette wheel selector: random and directed clear, load,
// select and unused-op requests, with results predicted in the bench itself.
// Depends on rws_pkg, rws_if and roulette_wheel_selector from the RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = rws_pkg::DEPTH_DEF;

    // op code 3 has no name in the package; the block must treat it as a no-op
    localparam logic [rws_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // stimulus and pressure sizing
    localparam int N_REQS        = 950;   // stop queueing random sessions past this
    localparam int HOLD_AT       = 300;   // accepted requests before the long receiver stall
    localparam int HOLD_CYCLES   = 400;   // length of that stall
    localparam int SETTLE_CYCLES = 40;    // settling time after the drain
    localparam int MAX_REPORTS   = 10;

    // one request as queued for the driver; wait_idle holds it back until
    // every outstanding result has come back
    typedef struct packed {
        logic [rws_pkg::OP_W-1:0]    op;
        logic [rws_pkg::SCORE_W-1:0] score;
        logic [rws_pkg::RAND_W-1:0]  rand_value;
        logic                        wait_idle;
    } t_wheel_req;

    typedef struct packed {
        logic [rws_pkg::IDX_W-1:0]   sel_idx;
        logic [rws_pkg::TOTAL_W-1:0] total;
        logic [rws_pkg::COUNT_W-1:0] count;
        logic                        overflow;
    } t_wheel_result;

    // receiver stall patterns, switched every so often
    typedef enum logic [1:0] {
        RX_STREAM,   // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready one cycle in four on average
        RX_PATTERN   // fixed pattern: low one cycle out of eight
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    rws_req_if req_bus ();
    rws_rsp_if rsp_bus ();

    roulette_wheel_selector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Wheel predictor: own copy of the cumulative sums, count and total.
    // ------------------------------------------------------------------
    logic [rws_pkg::TOTAL_W-1:0] cum_sums [DEPTH];
    int unsigned                 wheel_entries;
    logic [rws_pkg::TOTAL_W-1:0] wheel_total;

    // results still owed by the block, oldest first
    t_wheel_result wheel_expected [$];

    // what the run went through, for the closing summary
    int unsigned n_clears, n_loads, n_drops, n_selects, n_misses, n_unused, n_full_picks;

    // Applies one accepted request to the wheel and returns the result it must produce.
    function automatic t_wheel_result spin_wheel(t_wheel_req r);
        t_wheel_result               res;
        logic [rws_pkg::TOTAL_W:0]   sum;
        logic [63:0]                 threshold;
        bit                          found;
        res = '0;
        case (r.op)
            rws_pkg::OP_CLEAR: begin
                wheel_entries = 0;
                wheel_total   = '0;
                n_clears++;
            end
            rws_pkg::OP_LOAD: begin
                n_loads++;
                if (wheel_entries >= DEPTH) begin
                    // table full: nothing changes, the load is flagged as dropped
                    res.overflow = 1'b1;
                    n_drops++;
                end else begin
                    sum = {1'b0, wheel_total} + (rws_pkg::TOTAL_W+1)'(r.score);
                    wheel_total = (sum > {1'b0, rws_pkg::SUM_MAX}) ? rws_pkg::SUM_MAX
                                                                  : sum[rws_pkg::TOTAL_W-1:0];
                    cum_sums[wheel_entries] = wheel_total;
                    wheel_entries++;
                end
            end
            rws_pkg::OP_SELECT: begin
                n_selects++;
                found = 1'b0;
                if (wheel_entries != 0) begin
                    threshold = (64'(wheel_total) * 64'(r.rand_value))
                              / 64'(rws_pkg::WHEEL_SCALE);
                    for (int i = 0; i < wheel_entries; i++) begin
                        if (!found && 64'(cum_sums[i]) >= threshold) begin
                            res.sel_idx = rws_pkg::IDX_W'(i);
                            found       = 1'b1;
                        end
                    end
                    if (wheel_entries == DEPTH) n_full_picks++;
                end
                // empty wheel or no entry reaching the threshold both give index 0
                if (!found) n_misses++;
            end
            default: n_unused++;
        endcase
        res.total = wheel_total;
        res.count = rws_pkg::COUNT_W'(wheel_entries);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue and helpers that fill it.
    // ------------------------------------------------------------------
    t_wheel_req pending_reqs [$];
    int         total_reqs;

    task automatic add_req(logic [rws_pkg::OP_W-1:0] op, logic [rws_pkg::SCORE_W-1:0] score,
                           logic [rws_pkg::RAND_W-1:0] draw, logic wait_idle);
        t_wheel_req r;
        r.op         = op;
        r.score      = score;
        r.rand_value = draw;
        r.wait_idle  = wait_idle;
        pending_reqs.push_back(r);
    endtask

    // scores: mostly full-range random, with zero, max and small values mixed in
    function automatic logic [rws_pkg::SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return rws_pkg::SCORE_W'($urandom_range(0, 15));
            default: return rws_pkg::SCORE_W'($urandom);
        endcase
    endfunction

    // draws: mostly the nominal 0..9999, sometimes past the scale to force misses
    function automatic logic [rws_pkg::RAND_W-1:0] pick_draw();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return rws_pkg::RAND_W'(rws_pkg::WHEEL_SCALE - 1);
            2, 3:    return rws_pkg::RAND_W'($urandom_range(int'(rws_pkg::WHEEL_SCALE),
                                                            (1 << rws_pkg::RAND_W) - 1));
            default: return rws_pkg::RAND_W'($urandom_range(0,
                                                            int'(rws_pkg::WHEEL_SCALE) - 1));
        endcase
    endfunction

    // A well-formed session: clear, a run of loads, then selects with a few
    // late loads mixed in. max_scores gives the run of loads the score 65535.
    task automatic add_session(int num_loads, int num_selects, bit max_scores);
        add_req(rws_pkg::OP_CLEAR, rws_pkg::SCORE_W'($urandom), rws_pkg::RAND_W'($urandom),
                $urandom_range(0, 3) == 0);
        for (int i = 0; i < num_loads; i++)
            add_req(rws_pkg::OP_LOAD, max_scores ? '1 : pick_score(),
                    rws_pkg::RAND_W'($urandom), 1'b0);
        for (int i = 0; i < num_selects; i++) begin
            if ($urandom_range(0, 5) == 0)
                add_req(rws_pkg::OP_LOAD, pick_score(), rws_pkg::RAND_W'($urandom), 1'b0);
            add_req(rws_pkg::OP_SELECT, rws_pkg::SCORE_W'($urandom), pick_draw(), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes inputs on the falling edge, bursts and gaps.
    // ------------------------------------------------------------------
    logic       req_taken;     // set by the monitor when a request handshakes
    int         burst_left;
    int         gap_left;
    t_wheel_req next_req;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (req_bus.valid && !req_taken) begin
            // current request not taken yet: hold everything steady
        end else begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].wait_idle || wheel_expected.size() == 0)) begin
                next_req = pending_reqs.pop_front();
                req_bus.valid      <= 1'b1;
                req_bus.op         <= next_req.op;
                req_bus.score      <= next_req.score;
                req_bus.rand_value <= next_req.rand_value;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    // a third of the bursts run back to back with no gap at all
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response receiver: ready follows a changing stall pattern, plus one
    // long hold-off so the output register fills and the input backs up.
    // ------------------------------------------------------------------
    t_rx_mode rx_mode;
    int       rx_cycle;
    logic     rx_hold_off;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 48 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_STREAM:  rsp_bus.ready <= !rx_hold_off;
                RX_COIN:    rsp_bus.ready <= !rx_hold_off && $urandom_range(0, 1) == 1;
                RX_SPARSE:  rsp_bus.ready <= !rx_hold_off && $urandom_range(0, 3) == 0;
                default:    rsp_bus.ready <= !rx_hold_off && (rx_cycle % 8 != 0);
            endcase
        end
    end

    int unsigned reqs_accepted;

    initial begin
        rx_hold_off = 1'b0;
        while (reqs_accepted < HOLD_AT) @(posedge i_clk);
        rx_hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold_off = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge. Accepted requests
    // go through the predictor; responses are checked against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    t_wheel_result rsp_seen;
    int unsigned   rsps_checked;
    int unsigned   fail_cnt;

    task automatic note_failure(string what);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_result(t_wheel_result got);
        t_wheel_result want;
        if (wheel_expected.size() == 0) begin
            note_failure($sformatf("response with nothing outstanding: idx %0d total %0d",
                                   got.sel_idx, got.total));
            return;
        end
        want = wheel_expected.pop_front();
        if (got.sel_idx !== want.sel_idx)
            note_failure($sformatf("response %0d selected_index expected %0d got %0d",
                                   rsps_checked, want.sel_idx, got.sel_idx));
        if (got.total !== want.total)
            note_failure($sformatf("response %0d total_weight expected %0d got %0d",
                                   rsps_checked, want.total, got.total));
        if (got.count !== want.count)
            note_failure($sformatf("response %0d entry_total expected %0d got %0d",
                                   rsps_checked, want.count, got.count));
        if (got.overflow !== want.overflow)
            note_failure($sformatf("response %0d overflow expected %0b got %0b",
                                   rsps_checked, want.overflow, got.overflow));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                wheel_expected.push_back(spin_wheel({req_bus.op, req_bus.score,
                                                     req_bus.rand_value, 1'b0}));
                req_taken = 1'b1;
                reqs_accepted++;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                rsp_seen = {rsp_bus.selected_index, rsp_bus.total_weight,
                            rsp_bus.entry_total, rsp_bus.overflow};
                check_result(rsp_seen);
                rsps_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, reset, wait for the drain, report.
    // ------------------------------------------------------------------
    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.op         = rws_pkg::OP_CLEAR;
        req_bus.score      = '0;
        req_bus.rand_value = '0;
        rsp_bus.ready      = 1'b0;
        req_taken     = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        rx_mode       = RX_STREAM;
        rx_cycle      = 0;
        wheel_entries = 0;
        wheel_total   = '0;

        // directed: empty wheel, unused op, score and draw extremes, clear
        add_req(rws_pkg::OP_SELECT, '0, '0, 1'b0);             // select on an empty wheel
        add_req(rws_pkg::OP_SELECT, '1, '1, 1'b0);
        add_req(OP_UNUSED, '0, '0, 1'b0);                      // unused op, empty wheel
        add_req(rws_pkg::OP_LOAD,   '0, '0, 1'b0);             // zero score
        add_req(rws_pkg::OP_LOAD,   '1, '0, 1'b0);             // largest score
        add_req(rws_pkg::OP_LOAD,   16'd1, '0, 1'b0);
        add_req(rws_pkg::OP_SELECT, '0, '0, 1'b0);             // threshold zero
        add_req(rws_pkg::OP_SELECT, '0, 14'd1, 1'b0);
        add_req(rws_pkg::OP_SELECT, '0, rws_pkg::RAND_W'(rws_pkg::WHEEL_SCALE - 1), 1'b0);
        add_req(rws_pkg::OP_SELECT, '0, rws_pkg::WHEEL_SCALE, 1'b0);  // draw at the scale
        add_req(rws_pkg::OP_SELECT, '0, '1, 1'b0);             // threshold above total: miss
        add_req(OP_UNUSED, '1, '1, 1'b0);                      // unused op on a loaded wheel
        add_req(rws_pkg::OP_LOAD,   16'h5555, 14'h2AAA, 1'b0);
        add_req(rws_pkg::OP_LOAD,   16'hAAAA, 14'h1555, 1'b0);
        add_req(rws_pkg::OP_SELECT, 16'hAAAA, 14'h1555, 1'b0);
        add_req(rws_pkg::OP_SELECT, 16'h5555, 14'h2AAA, 1'b0);
        add_req(rws_pkg::OP_SELECT, '0, 14'd5000, 1'b0);
        add_req(rws_pkg::OP_CLEAR,  '1, '1, 1'b0);
        add_req(rws_pkg::OP_SELECT, '0, 14'd5000, 1'b0);       // select right after clear
        add_req(rws_pkg::OP_LOAD,   16'd7, '0, 1'b1);          // sender waits for the drain
        add_req(rws_pkg::OP_SELECT, '0, 14'd9000, 1'b0);

        // fill the table with max scores, then push past the end to drop loads
        add_session(DEPTH + 3, 8, 1'b1);

        while (pending_reqs.size() < N_REQS) begin
            case ($urandom_range(0, 19))
                0: begin
                    // only while there is room, to keep the request count near the target
                    if (pending_reqs.size() + DEPTH + 20 <= N_REQS)
                        add_session(DEPTH + $urandom_range(1, 4), $urandom_range(4, 10), 1'b0);
                end
                1, 2, 3: begin
                    // noise: any op with any field values
                    repeat ($urandom_range(1, 6))
                        add_req(rws_pkg::OP_W'($urandom), rws_pkg::SCORE_W'($urandom),
                                rws_pkg::RAND_W'($urandom), 1'b0);
                end
                default: add_session($urandom_range(0, 20), $urandom_range(1, 8), 1'b0);
            endcase
        end
        total_reqs = pending_reqs.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (reqs_accepted < total_reqs) @(posedge i_clk);
        while (wheel_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (wheel_expected.size() != 0)
            note_failure($sformatf("%0d results never arrived", wheel_expected.size()));

        $display("covered %0d requests: %0d loads (%0d dropped on a full table), %0d selects",
                 reqs_accepted, n_loads, n_drops, n_selects);
        $display({"  %0d selects gave no match or hit an empty wheel, %0d on a full wheel, ",
                  "%0d clears, %0d unused ops; %0d mismatches"},
                 n_misses, n_full_picks, n_clears, n_unused, fail_cnt);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run ends here if the block hangs
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/rws_pkg.sv
hw/rtl/rws_if.sv
hw/rtl/roulette_wheel_selector.sv
test/tb.sv
